// ===== src/rmr_pkg.sv =====
// Package: shared widths, defaults and sequencer states for the rational multiply-reduce unit.
`timescale 1ns / 1ps

package rmr_pkg;

  localparam int unsigned FIELD_W            = 32;
  localparam int unsigned RESULT_W           = 64;
  localparam int unsigned DEF_OPERAND_WIDTH  = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_N,
    ST_MUL_D,
    ST_CHECK,
    ST_TWO,
    ST_ODD,
    ST_DN_GO,
    ST_DN_WT,
    ST_DD_GO,
    ST_DD_WT
  } rmr_state_e;

endpackage

// ===== src/rmr_divider.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module rmr_divider #(
  parameter int unsigned PW = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [PW-1:0] dividend_i,
  input  logic [PW-1:0] divisor_i,
  output logic          done_o,
  output logic [PW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(PW + 1);

  logic            run_q, run_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PW-1:0]   rem_q, rem_d;
  logic [PW-1:0]   quo_q, quo_d;
  logic [PW:0]     trial;
  logic [PW:0]     diff;
  logic            ge;

  assign trial = {rem_q, quo_q[PW-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign ge    = trial >= {1'b0, divisor_i};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CntW'(PW);
      rem_d = '0;
      quo_d = dividend_i;
    end else if (run_q) begin
      rem_d = ge ? diff[PW-1:0] : trial[PW-1:0];
      quo_d = {quo_q[PW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== src/rational_multiply_reduce_unit.sv =====
// Top level: multiplies two signed fractions and reduces the product to lowest terms.
`timescale 1ns / 1ps

// A transaction is taken when start is high and busy is low; busy then stays high until
// the result is shown. The result appears on prod_num_o/prod_den_o for exactly one
// cycle with done_o high and must be captured then: there is no way to hold it. One shared
// multiplier forms both products, a subtract/compare unit runs a binary GCD (first
// stripping common factors of two, then odd subtract-and-halve steps), and one restoring
// divider produces both quotients at one bit a cycle. When both products are zero the
// result is 0/0 and no division runs; when exactly one of them is zero the GCD loop is
// skipped; otherwise the GCD loop sets the spread in how long an item takes.
module rational_multiply_reduce_unit #(
  parameter int unsigned OPERAND_WIDTH = rmr_pkg::DEF_OPERAND_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [rmr_pkg::FIELD_W-1:0]  a_num_i,
  input  logic [rmr_pkg::FIELD_W-1:0]  a_den_i,
  input  logic [rmr_pkg::FIELD_W-1:0]  b_num_i,
  input  logic [rmr_pkg::FIELD_W-1:0]  b_den_i,
  output logic                         done_o,
  output logic [rmr_pkg::RESULT_W-1:0] prod_num_o,
  output logic [rmr_pkg::RESULT_W-1:0] prod_den_o
);

  import rmr_pkg::*;

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned PW = 2 * OPERAND_WIDTH;

  function automatic logic [W-1:0] mag_of(input logic [FIELD_W-1:0] raw);
    logic [W-1:0] v;
    v = raw[W-1:0];
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [RESULT_W-1:0] join_signed(input logic [PW-1:0] mag,
                                                      input logic neg);
    logic [RESULT_W-1:0] m;
    m = RESULT_W'(mag);
    return neg ? (~m + 1'b1) : m;
  endfunction

  rmr_state_e state_q, state_d;

  logic [W-1:0]        ma_q, mb_q, mda_q, mdb_q;
  logic                sn_q, sd_q;
  logic [PW-1:0]       pn_q, pn_d, pd_q, pd_d;
  logic [PW-1:0]       x_q, x_d, y_q, y_d;
  logic                done_q, done_d;
  logic [RESULT_W-1:0] num_q, num_d, den_q, den_d;

  logic [W-1:0]  mul_a, mul_b;
  logic [PW-1:0] mul_p;
  logic          x_gt_y;
  logic [PW-1:0] big, sml;
  logic          accept;
  logic          div_start, div_done;
  logic [PW-1:0] div_dividend, div_quo;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  assign mul_a = (state_q == ST_MUL_N) ? ma_q : mda_q;
  assign mul_b = (state_q == ST_MUL_N) ? mb_q : mdb_q;
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  assign x_gt_y = x_q > y_q;
  assign big    = x_gt_y ? x_q : y_q;
  assign sml    = x_gt_y ? y_q : x_q;

  rmr_divider #(
    .PW(PW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (x_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start) state_d = ST_MUL_N;
      ST_MUL_N: state_d = ST_MUL_D;
      ST_MUL_D: state_d = ST_CHECK;
      ST_CHECK: begin
        if (pn_q == '0 && pd_q == '0) begin
          state_d = ST_IDLE;
        end else if (pn_q == '0 || pd_q == '0) begin
          state_d = ST_DN_GO;
        end else begin
          state_d = ST_TWO;
        end
      end
      ST_TWO:   if (x_q[0] || y_q[0]) state_d = ST_ODD;
      ST_ODD:   if (x_q == y_q) state_d = ST_DN_GO;
      ST_DN_GO: state_d = ST_DN_WT;
      ST_DN_WT: if (div_done) state_d = ST_DD_GO;
      ST_DD_GO: state_d = ST_DD_WT;
      ST_DD_WT: if (div_done) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    pn_d         = pn_q;
    pd_d         = pd_q;
    x_d          = x_q;
    y_d          = y_q;
    done_d       = 1'b0;
    num_d        = num_q;
    den_d        = den_q;
    div_start    = 1'b0;
    div_dividend = pn_q;
    unique case (state_q)
      ST_IDLE: ;
      ST_MUL_N: pn_d = mul_p;
      ST_MUL_D: pd_d = mul_p;
      ST_CHECK: begin
        x_d = (pn_q == '0) ? pd_q : pn_q;
        y_d = pd_q;
        if (pn_q == '0 && pd_q == '0) begin
          done_d = 1'b1;
          num_d  = '0;
          den_d  = '0;
        end
      end
      ST_TWO: begin
        if (!(x_q[0] || y_q[0])) begin
          x_d  = x_q >> 1;
          y_d  = y_q >> 1;
          pn_d = pn_q >> 1;
          pd_d = pd_q >> 1;
        end
      end
      ST_ODD: begin
        if (x_q != y_q) begin
          if (!x_q[0]) begin
            x_d = x_q >> 1;
          end else if (!y_q[0]) begin
            y_d = y_q >> 1;
          end else begin
            x_d = big - sml;
            y_d = sml;
          end
        end
      end
      ST_DN_GO: div_start = 1'b1;
      ST_DN_WT: if (div_done) pn_d = div_quo;
      ST_DD_GO: begin
        div_start    = 1'b1;
        div_dividend = pd_q;
      end
      ST_DD_WT: begin
        div_dividend = pd_q;
        if (div_done) begin
          done_d = 1'b1;
          num_d  = join_signed(pn_q, sn_q);
          den_d  = join_signed(div_quo, sd_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ma_q  <= mag_of(a_num_i);
      mda_q <= mag_of(a_den_i);
      mb_q  <= mag_of(b_num_i);
      mdb_q <= mag_of(b_den_i);
      sn_q  <= a_num_i[W-1] ^ b_num_i[W-1];
      sd_q  <= a_den_i[W-1] ^ b_den_i[W-1];
    end
    pn_q  <= pn_d;
    pd_q  <= pd_d;
    x_q   <= x_d;
    y_q   <= y_d;
    num_q <= num_d;
    den_q <= den_d;
  end

  assign done_o     = done_q;
  assign prod_num_o = num_q;
  assign prod_den_o = den_q;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("transaction accepted but unit not busy");

  a_odd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ODD) |-> (x_q != '0 && y_q != '0))
    else $error("gcd operand reached zero");

  a_zero_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && prod_num_o == '0) |->
      (prod_den_o == '0 || prod_den_o == RESULT_W'(1) || prod_den_o == '1))
    else $error("zero numerator not reduced to unit denominator");
`endif

endmodule

// ===== tb/product_reduce_checker.sv =====
// Checker for the rational multiply-reduce unit: predicts each reduced product and compares.
`timescale 1ns / 1ps

module product_reduce_checker #(
  parameter int unsigned OPERAND_WIDTH = rmr_pkg::DEF_OPERAND_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  logic                         busy,
  input  logic [rmr_pkg::FIELD_W-1:0]  a_num_i,
  input  logic [rmr_pkg::FIELD_W-1:0]  a_den_i,
  input  logic [rmr_pkg::FIELD_W-1:0]  b_num_i,
  input  logic [rmr_pkg::FIELD_W-1:0]  b_den_i,
  input  logic                         done_o,
  input  logic [rmr_pkg::RESULT_W-1:0] prod_num_o,
  input  logic [rmr_pkg::RESULT_W-1:0] prod_den_o,
  output int                           fail_count,
  output int                           pending,
  output int                           checked,
  output int                           zero_num_seen,
  output int                           zero_den_seen
);

  typedef struct packed {
    logic [rmr_pkg::RESULT_W-1:0] num;
    logic [rmr_pkg::RESULT_W-1:0] den;
  } fraction_t;

  fraction_t expected_q[$];

  function automatic logic [63:0] operand_magnitude(input logic [31:0] raw, output logic neg);
    logic [63:0] mask;
    logic [63:0] v;
    mask = (64'd1 << OPERAND_WIDTH) - 64'd1;
    v    = {32'd0, raw} & mask;
    neg  = v[OPERAND_WIDTH-1];
    return neg ? ((~v + 64'd1) & mask) : v;
  endfunction

  function automatic logic [63:0] common_divisor(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] t;
    while (y != 64'd0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic fraction_t reduced_product(input logic [31:0] an, input logic [31:0] ad,
                                                input logic [31:0] bn, input logic [31:0] bd);
    logic [63:0] ma, mda, mb, mdb, pn, pd, g;
    logic        na, da, nb, db;
    fraction_t   r;
    ma  = operand_magnitude(an, na);
    mda = operand_magnitude(ad, da);
    mb  = operand_magnitude(bn, nb);
    mdb = operand_magnitude(bd, db);
    pn  = ma * mb;
    pd  = mda * mdb;
    g   = common_divisor(pn, pd);
    if (g != 64'd0) begin
      pn = pn / g;
      pd = pd / g;
    end
    r.num = (na != nb) ? (64'd0 - pn) : pn;
    r.den = (da != db) ? (64'd0 - pd) : pd;
    return r;
  endfunction

  initial begin
    fail_count    = 0;
    pending       = 0;
    checked       = 0;
    zero_num_seen = 0;
    zero_den_seen = 0;
  end

  always @(posedge clk_i) begin
    fraction_t want;
    if (rst_ni) begin
      // compare first: a result on the same edge as an accept belongs to an older transaction
      if (done_o) begin
        checked++;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] unexpected result %0d/%0d", $realtime,
                     $signed(prod_num_o), $signed(prod_den_o));
        end else begin
          want = expected_q.pop_front();
          if (want.num !== prod_num_o || want.den !== prod_den_o) begin
            fail_count++;
            if (fail_count <= 10)
              $display("[%0t] mismatch: expected %0d/%0d, got %0d/%0d", $realtime,
                       $signed(want.num), $signed(want.den),
                       $signed(prod_num_o), $signed(prod_den_o));
          end
        end
      end
      if (start && !busy) begin
        want = reduced_product(a_num_i, a_den_i, b_num_i, b_den_i);
        if (want.num == 64'd0) zero_num_seen++;
        if (want.den == 64'd0) zero_den_seen++;
        expected_q.push_back(want);
      end
      pending = expected_q.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Testbench top for the rational multiply-reduce unit: stimulus, reset, timeout and verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned OPW = rmr_pkg::DEF_OPERAND_WIDTH;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start;
  logic                         busy;
  logic [rmr_pkg::FIELD_W-1:0]  a_num_i;
  logic [rmr_pkg::FIELD_W-1:0]  a_den_i;
  logic [rmr_pkg::FIELD_W-1:0]  b_num_i;
  logic [rmr_pkg::FIELD_W-1:0]  b_den_i;
  logic                         done_o;
  logic [rmr_pkg::RESULT_W-1:0] prod_num_o;
  logic [rmr_pkg::RESULT_W-1:0] prod_den_o;

  int fail_count;
  int pending;
  int checked;
  int zero_num_seen;
  int zero_den_seen;
  int sent;
  int idle_pct[4] = '{0, 50, 0, 37};

  rational_multiply_reduce_unit #(.OPERAND_WIDTH(OPW)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .a_num_i    (a_num_i),
    .a_den_i    (a_den_i),
    .b_num_i    (b_num_i),
    .b_den_i    (b_den_i),
    .done_o     (done_o),
    .prod_num_o (prod_num_o),
    .prod_den_o (prod_den_o)
  );

  product_reduce_checker #(.OPERAND_WIDTH(OPW)) checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .a_num_i       (a_num_i),
    .a_den_i       (a_den_i),
    .b_num_i       (b_num_i),
    .b_den_i       (b_den_i),
    .done_o        (done_o),
    .prod_num_o    (prod_num_o),
    .prod_den_o    (prod_den_o),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked       (checked),
    .zero_num_seen (zero_num_seen),
    .zero_den_seen (zero_den_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #80ms;
    $display("timeout with %0d results outstanding", pending);
    $display("rational_multiply_reduce_unit test failed");
    $finish;
  end

  // called just after a falling edge; returns just after the falling edge past acceptance
  task automatic send_fraction_pair(input logic [31:0] an, input logic [31:0] ad,
                                    input logic [31:0] bn, input logic [31:0] bd,
                                    input int idle);
    int gap;
    if ($urandom_range(99) < idle) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(1, 400) : $urandom_range(1, 8);
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start   = 1'b1;
    a_num_i = an;
    a_den_i = ad;
    b_num_i = bn;
    b_den_i = bd;
    do @(posedge clk_i); while (busy);
    sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] random_operand();
    logic [31:0] v;
    case ($urandom_range(9))
      0, 1, 2: v = $urandom();
      3, 4:    v = 32'($urandom_range(200)) - 32'd100;
      5: begin
        case ($urandom_range(5))
          0:       v = 32'd0;
          1:       v = 32'd1;
          2:       v = 32'hFFFF_FFFF;
          3:       v = 32'h7FFF_FFFF;
          4:       v = 32'h8000_0000;
          default: v = 32'h8000_0001;
        endcase
      end
      6: begin
        v = (32'($urandom_range(63)) | 32'd1) << $urandom_range(24);
        if ($urandom_range(1)) v = 32'd0 - v;
      end
      7:       v = 32'd0;
      default: v = $urandom() >> $urandom_range(31);
    endcase
    return v;
  endfunction

  initial begin
    logic [31:0] an, ad, bn, bd, k;
    start   = 1'b0;
    a_num_i = '0;
    a_den_i = '0;
    b_num_i = '0;
    b_den_i = '0;
    sent    = 0;
    rst_ni  = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // zero numerator, zero denominator, both zero
    send_fraction_pair(32'd0, 32'd1, 32'd3, 32'd4, 0);
    send_fraction_pair(32'd0, 32'd6, 32'd5, 32'hFFFF_FFF9, 0);
    send_fraction_pair(32'd5, 32'd0, 32'd3, 32'd7, 0);
    send_fraction_pair(32'hFFFF_FFFB, 32'd2, 32'd3, 32'd0, 0);
    send_fraction_pair(32'd0, 32'd0, 32'd9, 32'd4, 0);
    send_fraction_pair(32'd0, 32'd0, 32'd0, 32'd0, 0);
    // integer factor and plain reductions
    send_fraction_pair(32'd3, 32'd4, 32'd8, 32'd1, 0);
    send_fraction_pair(32'd6, 32'd35, 32'd14, 32'd9, 0);
    send_fraction_pair(32'hFFFF_FFFE, 32'd3, 32'd9, 32'hFFFF_FFFC, 0);
    send_fraction_pair(32'd1, 32'd1, 32'd1, 32'd1, 0);
    send_fraction_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    // extremes of the operand range
    send_fraction_pair(32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1, 0);
    send_fraction_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send_fraction_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001, 0);
    send_fraction_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_fraction_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'h8000_0000, 0);
    send_fraction_pair(32'h4000_0000, 32'h0000_0003, 32'h0000_0006, 32'h2000_0000, 0);
    send_fraction_pair(32'h7FFF_FFFF, 32'd2, 32'd4, 32'h7FFF_FFFF, 0);
    send_fraction_pair(32'd1, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 0);
    send_fraction_pair(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, 0);

    for (int p = 0; p < 4; p++) begin
      for (int i = 0; i < 320; i++) begin
        an = random_operand();
        ad = random_operand();
        bn = random_operand();
        bd = random_operand();
        if ($urandom_range(99) < 30) begin
          k  = 32'($urandom_range(1, 1000));
          an = an * k;
          bd = bd * k;
          k  = 32'($urandom_range(1, 1000));
          bn = bn * k;
          ad = ad * k;
        end
        if ($urandom_range(99) < 15) bd = 32'd1;
        send_fraction_pair(an, ad, bn, bd, idle_pct[p]);
      end
    end
    start = 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (1000) @(negedge clk_i);

    $display("%0d transactions sent, %0d results checked, %0d mismatches", sent, checked,
             fail_count);
    $display("%0d products reduced to a zero numerator, %0d to a zero denominator",
             zero_num_seen, zero_den_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("rational_multiply_reduce_unit test passed");
    end else begin
      $display("rational_multiply_reduce_unit test failed");
    end
    $finish;
  end

endmodule
